>>> sv/healpix_ring_to_nested_index_unit_macros.svh
// Assertion macros for the HEALPix ring-to-nested index unit.
`ifndef HEALPIX_RING_TO_NESTED_INDEX_UNIT_MACROS_SVH
`define HEALPIX_RING_TO_NESTED_INDEX_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define HPX_R2N_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hpx_r2n: same-cycle check failed");

// next-cycle implication
`define HPX_R2N_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hpx_r2n: next-cycle check failed");

`else

`define HPX_R2N_ASSERT_IMPL(label, clk, rst, ante, cons)

`define HPX_R2N_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/hpx_r2n_pkg.sv
// Types, constants and helper functions of the HEALPix ring-to-nested index unit.
`timescale 1ns / 1ps

package hpx_r2n_pkg;

   localparam int IDX_W          = 30;
   localparam int K_W            = 4;
   localparam int MAX_NSIDE_LOG2 = 13;
   localparam int SQ_STEPS       = MAX_NSIDE_LOG2 + 1;
   localparam int RAD_W          = 2 * SQ_STEPS;
   localparam int M_W            = RAD_W - 1;
   localparam int NR_W           = MAX_NSIDE_LOG2 + 1;
   localparam int RING_W         = MAX_NSIDE_LOG2 + 3;
   localparam int BT_W           = MAX_NSIDE_LOG2 + 2;
   localparam int IXY_W          = MAX_NSIDE_LOG2;
   localparam int SW             = RING_W + 4;
   localparam int FACE_W         = 4;
   localparam int LON_W          = 3;
   localparam int CSR_IDX_W      = 4;
   localparam int CSR_DATA_W     = 4;

   localparam logic [K_W-1:0]    K_MAX     = K_W'(MAX_NSIDE_LOG2);
   localparam logic [FACE_W-1:0] FACE_LAST = FACE_W'(11);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NSIDE_LOG2  = 4'd0,
      CSR_NESTED_MODE = 4'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ZONE_NORTH = 2'd0,
      ZONE_BELT  = 2'd1,
      ZONE_SOUTH = 2'd2
   } zone_type;

   typedef struct packed {
      logic [IDX_W-1:0]  pix;
      logic [K_W-1:0]    k;
      logic              mode;
      logic              err;
      zone_type          zone;
      logic [IDX_W-1:0]  npix;
      logic [IDX_W-1:0]  ncap;
      logic [IDX_W-1:0]  scap;
      logic [M_W-1:0]    m;
      logic [RAD_W-1:0]  rad;
      logic [RAD_W-1:0]  root;
      logic [NR_W-1:0]   nr;
      logic [RAD_W-1:0]  tnr;
      logic [RING_W-1:0] iring;
      logic [RING_W-1:0] iphi;
      logic [BT_W-1:0]   btmp;
      logic              kshift;
      logic [FACE_W-1:0] face;
      logic [SW-1:0]     irt;
      logic [SW-1:0]     ipt;
   } pipe_type;

   // longitude code of each base face
   function automatic logic [LON_W-1:0] face_lon(input logic [FACE_W-1:0] face);
      case (face)
         4'd0:    face_lon = 3'd1;
         4'd1:    face_lon = 3'd3;
         4'd2:    face_lon = 3'd5;
         4'd3:    face_lon = 3'd7;
         4'd4:    face_lon = 3'd0;
         4'd5:    face_lon = 3'd2;
         4'd6:    face_lon = 3'd4;
         4'd7:    face_lon = 3'd6;
         4'd8:    face_lon = 3'd1;
         4'd9:    face_lon = 3'd3;
         4'd10:   face_lon = 3'd5;
         4'd11:   face_lon = 3'd7;
         default: face_lon = 3'd0;
      endcase
   endfunction

   // Morton spread: bit b goes to bit 2b
   function automatic logic [2*IXY_W-1:0] spread_bits(input logic [IXY_W-1:0] v);
      logic [2*IXY_W-1:0] r;
      r = '0;
      for (int b = 0; b < IXY_W; b++) begin
         r[2*b] = v[b];
      end
      return r;
   endfunction

endpackage

>>> sv/healpix_ring_to_nested_index_unit.sv
// HEALPix ring-to-nested index unit: top level with the full conversion pipeline.
// Converts one HEALPix ring-ordered pixel index per cycle into nested order for
// Nside = 2^nside_log2 (values above 13 act as 13). Register 0 holds nside_log2
// (reset 0), register 1 nested_mode (reset 1; 0 passes valid indices unchanged).
// Indices at or beyond 12*Nside^2 return zero with index_error set. The datapath
// is a 22-register pipeline: zone split, a 14-stage one-bit-per-stage integer
// square root, ring/face decode and the Morton interleave. One transaction is
// taken every cycle while req_stall is low. Stalls on the result side fill empty
// stages first, so req_stall rises only when every stage holds a transaction.
`timescale 1ns / 1ps
`include "healpix_ring_to_nested_index_unit_macros.svh"

module healpix_ring_to_nested_index_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [hpx_r2n_pkg::IDX_W-1:0]       req_ring_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [hpx_r2n_pkg::IDX_W-1:0]       rsp_nested_index,
   output logic                                rsp_index_error,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hpx_r2n_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hpx_r2n_pkg::CSR_DATA_W-1:0]  csr_data
);
   import hpx_r2n_pkg::*;

   localparam int ST_F1    = 1;
   localparam int ST_F2    = 2;
   localparam int SQ_FIRST = 3;
   localparam int ST_M     = SQ_FIRST + SQ_STEPS;
   localparam int ST_P     = ST_M + 1;
   localparam int ST_Q     = ST_P + 1;
   localparam int ST_R     = ST_Q + 1;
   localparam int NSTG     = ST_R + 1;

   logic [K_W-1:0]   nside_log2_ff, nside_log2_in;
   logic             nested_mode_ff, nested_mode_in;

   pipe_type         pipe_ff [NSTG];
   pipe_type         pipe_in [NSTG];
   logic [NSTG-1:0]  valid_ff, valid_in;
   logic [NSTG:0]    ld;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] rsp_nested_index_ff, rsp_nested_index_in;
   logic             rsp_index_error_ff, rsp_index_error_in;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      nside_log2_in  = nside_log2_ff;
      nested_mode_in = nested_mode_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NSIDE_LOG2:  nside_log2_in  = csr_data;
            CSR_NESTED_MODE: nested_mode_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nside_log2_ff  <= '0;
         nested_mode_ff <= 1'b1;
      end else begin
         nside_log2_ff  <= nside_log2_in;
         nested_mode_ff <= nested_mode_in;
      end
   end

   // stage load enables: a stage loads when the result register can advance or when it or any later stage is empty
   always_comb begin
      ld[NSTG] = !rsp_valid_ff || !rsp_stall;
      for (int i = 0; i < NSTG; i++) begin
         ld[i] = ld[NSTG] || !(&(valid_ff | ~({NSTG{1'b1}} << i)));
      end
      valid_in[0] = req_valid;
      for (int i = 1; i < NSTG; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
      rsp_valid_in = valid_ff[NSTG-1];
   end

   assign req_stall = !ld[0];

   // datapath
   always_comb begin : stage_logic
      pipe_type           cur;
      logic [K_W-1:0]     k_sat;
      logic [IDX_W-1:0]   ip;
      logic [IDX_W-1:0]   btmp_w;
      logic [M_W-1:0]     m_v;
      logic [RAD_W:0]     sq_sum;
      logic [RAD_W-1:0]   sq_bit;
      logic [NR_W-1:0]    nr_v;
      logic [2*NR_W-1:0]  prod;
      logic [RAD_W-1:0]   p_w;
      logic [RING_W-1:0]  p_v;
      logic [RING_W-1:0]  a_v;
      logic [RING_W-1:0]  b2_v;
      logic [RING_W-1:0]  b3_v;
      logic [1:0]         q_v;
      logic [RING_W:0]    am_v;
      logic [RING_W:0]    ap_v;
      logic [RING_W:0]    amq_v;
      logic [RING_W:0]    apq_v;
      logic [2:0]         ifm_v;
      logic [2:0]         ifp_v;
      logic [NR_W+LON_W-1:0] lon_nr;
      logic [SW-1:0]      irt_v;
      logic [SW-1:0]      ipt_v;
      logic [SW-1:0]      ix_v;
      logic [SW-1:0]      iy_v;
      logic [IXY_W:0]     nmask;
      logic [IXY_W-1:0]   ix_u;
      logic [IXY_W-1:0]   iy_u;
      logic [IDX_W-1:0]   res_v;

      // capture: resolution-dependent sizes
      k_sat = (nside_log2_ff > K_MAX) ? K_MAX : nside_log2_ff;
      pipe_in[0]      = '0;
      pipe_in[0].pix  = req_ring_index;
      pipe_in[0].k    = k_sat;
      pipe_in[0].mode = nested_mode_ff;
      pipe_in[0].npix = IDX_W'(12) << (2 * k_sat);
      pipe_in[0].ncap = (IDX_W'(1) << (2 * k_sat + 1)) - (IDX_W'(1) << (k_sat + 1));
      pipe_in[0].scap = pipe_in[0].npix - pipe_in[0].ncap;

      // range check and zone
      cur = pipe_ff[ST_F1-1];
      pipe_in[ST_F1] = cur;
      pipe_in[ST_F1].err = (cur.pix >= cur.npix);
      if (cur.pix < cur.ncap) begin
         pipe_in[ST_F1].zone = ZONE_NORTH;
      end else if (cur.pix >= cur.scap) begin
         pipe_in[ST_F1].zone = ZONE_SOUTH;
      end else begin
         pipe_in[ST_F1].zone = ZONE_BELT;
      end

      // cap offset for the root, belt ring and position
      cur = pipe_ff[ST_F2-1];
      pipe_in[ST_F2] = cur;
      case (cur.zone)
         ZONE_NORTH: m_v = cur.pix[M_W-1:0];
         ZONE_SOUTH: m_v = M_W'(cur.npix - cur.pix - IDX_W'(1));
         default:    m_v = '0;
      endcase
      ip     = cur.pix - cur.ncap;
      btmp_w = ip >> (cur.k + 2);
      pipe_in[ST_F2].m      = m_v;
      pipe_in[ST_F2].rad    = {m_v, 1'b1};
      pipe_in[ST_F2].root   = '0;
      pipe_in[ST_F2].btmp   = btmp_w[BT_W-1:0];
      pipe_in[ST_F2].iring  = RING_W'(btmp_w[BT_W-1:0]) + (RING_W'(1) << cur.k);
      pipe_in[ST_F2].iphi   = (ip[RING_W-1:0] & ((RING_W'(1) << (cur.k + 2)) - RING_W'(1)))
                              + RING_W'(1);
      pipe_in[ST_F2].kshift = (cur.zone == ZONE_BELT) ? btmp_w[0] : 1'b0;

      // integer square root, one result bit per stage
      for (int s = 0; s < SQ_STEPS; s++) begin
         cur = pipe_ff[SQ_FIRST+s-1];
         pipe_in[SQ_FIRST+s] = cur;
         sq_bit = RAD_W'(1) << (2 * (SQ_STEPS - 1 - s));
         sq_sum = {1'b0, cur.root} + {1'b0, sq_bit};
         if ({1'b0, cur.rad} >= sq_sum) begin
            pipe_in[SQ_FIRST+s].rad  = cur.rad - sq_sum[RAD_W-1:0];
            pipe_in[SQ_FIRST+s].root = (cur.root >> 1) + sq_bit;
         end else begin
            pipe_in[SQ_FIRST+s].root = cur.root >> 1;
         end
      end

      // ring number and pixels above it
      cur = pipe_ff[ST_M-1];
      pipe_in[ST_M] = cur;
      if (cur.zone == ZONE_BELT) begin
         nr_v = NR_W'(1) << cur.k;
      end else begin
         nr_v = NR_W'((cur.root[NR_W:0] + (NR_W+1)'(1)) >> 1);
      end
      prod = (2*NR_W)'(nr_v) * (2*NR_W)'(nr_v - NR_W'(1));
      pipe_in[ST_M].nr  = nr_v;
      pipe_in[ST_M].tnr = {prod[RAD_W-2:0], 1'b0};

      // cap ring and position in ring
      cur = pipe_ff[ST_P-1];
      pipe_in[ST_P] = cur;
      p_w = RAD_W'(cur.m) + RAD_W'(1) - cur.tnr;
      p_v = p_w[RING_W-1:0];
      if (cur.zone == ZONE_NORTH) begin
         pipe_in[ST_P].iphi  = p_v;
         pipe_in[ST_P].iring = RING_W'(cur.nr);
      end else if (cur.zone == ZONE_SOUTH) begin
         pipe_in[ST_P].iphi  = (RING_W'(cur.nr) << 2) + RING_W'(1) - p_v;
         pipe_in[ST_P].iring = (RING_W'(1) << (cur.k + 2)) - RING_W'(cur.nr);
      end

      // base face
      cur = pipe_ff[ST_Q-1];
      pipe_in[ST_Q] = cur;
      a_v  = cur.iphi - RING_W'(1);
      b2_v = RING_W'(cur.nr) << 1;
      b3_v = b2_v + RING_W'(cur.nr);
      if (a_v >= b2_v) begin
         q_v = (a_v >= b3_v) ? 2'd3 : 2'd2;
      end else begin
         q_v = (a_v >= RING_W'(cur.nr)) ? 2'd1 : 2'd0;
      end
      am_v  = (RING_W+1)'(cur.iphi) + ((RING_W+1)'(1) << cur.k) - (RING_W+1)'(1)
              - (RING_W+1)'((cur.btmp + BT_W'(1)) >> 1);
      apq_v = ((RING_W+1)'(1) << (cur.k + 1)) + (RING_W+1)'(1) - (RING_W+1)'(cur.btmp);
      ap_v  = (RING_W+1)'(cur.iphi) + ((RING_W+1)'(1) << cur.k) - (RING_W+1)'(1)
              - (apq_v >> 1);
      amq_v = am_v >> cur.k;
      ifm_v = amq_v[2:0];
      amq_v = ap_v >> cur.k;
      ifp_v = amq_v[2:0];
      case (cur.zone)
         ZONE_NORTH: pipe_in[ST_Q].face = {2'b00, q_v};
         ZONE_SOUTH: pipe_in[ST_Q].face = {2'b10, q_v};
         default: begin
            if (ifp_v == ifm_v) begin
               pipe_in[ST_Q].face = FACE_W'(ifp_v | 3'd4);
            end else if (ifp_v < ifm_v) begin
               pipe_in[ST_Q].face = FACE_W'(ifp_v);
            end else begin
               pipe_in[ST_Q].face = FACE_W'(ifm_v) + FACE_W'(8);
            end
         end
      endcase

      // face-relative ring and longitude
      cur = pipe_ff[ST_R-1];
      pipe_in[ST_R] = cur;
      lon_nr = (NR_W+LON_W)'(face_lon(cur.face)) * (NR_W+LON_W)'(cur.nr);
      irt_v  = SW'(cur.iring) - (SW'(32'd2 + 32'(cur.face[3:2])) << cur.k) + SW'(1);
      ipt_v  = (SW'(cur.iphi) << 1) - SW'(lon_nr) - SW'(cur.kshift) - SW'(1);
      if ($signed(ipt_v) >= $signed(SW'(1) << (cur.k + 1))) begin
         ipt_v = ipt_v - (SW'(1) << (cur.k + 3));
      end
      pipe_in[ST_R].irt = irt_v;
      pipe_in[ST_R].ipt = ipt_v;

      // face coordinates and Morton interleave
      cur   = pipe_ff[NSTG-1];
      ix_v  = cur.ipt - cur.irt;
      iy_v  = SW'(0) - cur.ipt - cur.irt;
      nmask = ((IXY_W+1)'(1) << cur.k) - (IXY_W+1)'(1);
      ix_u  = ix_v[SW-1] ? '0 : (ix_v[IXY_W:1] & nmask[IXY_W-1:0]);
      iy_u  = iy_v[SW-1] ? '0 : (iy_v[IXY_W:1] & nmask[IXY_W-1:0]);
      res_v = (IDX_W'(cur.face) << (2 * cur.k)) | IDX_W'(spread_bits(ix_u))
              | (IDX_W'(spread_bits(iy_u)) << 1);
      if (cur.err) begin
         rsp_nested_index_in = '0;
         rsp_index_error_in  = 1'b1;
      end else if (!cur.mode) begin
         rsp_nested_index_in = cur.pix;
         rsp_index_error_in  = 1'b0;
      end else begin
         rsp_nested_index_in = res_v;
         rsp_index_error_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (ld[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
         if (ld[NSTG]) begin
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTG; i++) begin
         if (ld[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
      if (ld[NSTG]) begin
         rsp_nested_index_ff <= rsp_nested_index_in;
         rsp_index_error_ff  <= rsp_index_error_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_nested_index = rsp_nested_index_ff;
   assign rsp_index_error  = rsp_index_error_ff;

   // checks
   `HPX_R2N_ASSERT_IMPL(a_cap_iphi_range, clock, reset, valid_ff[ST_P] && !pipe_ff[ST_P].err && pipe_ff[ST_P].zone != ZONE_BELT, pipe_ff[ST_P].iphi >= RING_W'(1) && pipe_ff[ST_P].iphi <= (RING_W'(pipe_ff[ST_P].nr) << 2))
   `HPX_R2N_ASSERT_IMPL(a_face_range, clock, reset, valid_ff[ST_Q] && !pipe_ff[ST_Q].err, pipe_ff[ST_Q].face <= FACE_LAST)
   `HPX_R2N_ASSERT_NEXT(a_last_stage_held, clock, reset, valid_ff[NSTG-1] && rsp_valid_ff && rsp_stall, valid_ff[NSTG-1] && rsp_valid_ff)
   `HPX_R2N_ASSERT_IMPL(a_stall_only_full, clock, reset, req_stall, (&valid_ff) && rsp_valid_ff)

endmodule
